// ===== rtl/battery_charge_from_voltage_core_macros.svh =====
// assertion macros shared by the charge estimator rtl
`ifndef BATTERY_CHARGE_FROM_VOLTAGE_CORE_MACROS_SVH
`define BATTERY_CHARGE_FROM_VOLTAGE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BCV_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("bcv same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BCV_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("bcv next-cycle check failed");

`endif

// ===== rtl/bcv_pkg.sv =====
// constants and discharge curve tables for the charge estimator
package bcv_pkg;

    // field widths
    localparam int CODE_W  = 12;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = CODE_W + MV_W;

    // configuration port
    localparam int        PADDR_W        = 3;
    localparam int        PDATA_W        = 32;
    localparam logic      REG_FULL_SCALE = 1'b0;
    localparam logic [MV_W-1:0] FULL_SCALE_RST = 16'd13200;

    // floor(p / 4095) as (p * DIV_RECIP) >> DIV_SHIFT, exact for p < 2**28
    localparam int                DIV_SHIFT = 40;
    localparam int                RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd268501009;

    // interpolation slope fixed point
    localparam int D_W       = 14;
    localparam int MUL_W     = 27;
    localparam int MUL_SHIFT = 27;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

    // discharge curve
    localparam int TABLE_MAX    = 16;
    localparam int CURVE_LEN_DEF = 12;

    localparam logic [MV_W-1:0] CURVE_MV [TABLE_MAX] = '{
        16'd8400, 16'd8100, 16'd7960, 16'd7840, 16'd7680, 16'd7520,
        16'd7400, 16'd7280, 16'd7140, 16'd6900, 16'd6600, 16'd6000,
        16'd0,    16'd0,    16'd0,    16'd0
    };

    localparam logic [PCT_W-1:0] CURVE_SOC [TABLE_MAX] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0,
        7'd0,   7'd0,  7'd0,  7'd0
    };

endpackage

// ===== rtl/battery_charge_from_voltage_core.sv =====
// pack voltage and state-of-charge estimator, four-stage pipeline
//
// usage:
//   input channel carries one adc_code item (in_valid / in_stall); output
//   channel carries pack_mv and charge_percent (out_valid / out_stall)
//   pack_mv = floor(adc_code * full_scale_mv / 4095)
//   charge_percent is linear interpolation on a fixed discharge curve,
//   100 at or above the top point, 0 at or below the bottom point
//   full_scale_mv is written over the apb port at byte address 0; the user
//   must write it only while idle, which the block does not enforce
// timing:
//   one item per cycle while out_stall is low, set by the scale, divide-by-4095
//   reciprocal and slope multipliers, each in a stage of its own
// reset:
//   rst_n clears all stage valid bits and loads full_scale_mv with 13200
// stall:
//   a stalled result holds on the outputs; stages behind it keep filling
//   until the pipeline is full, then in_stall rises; nothing is dropped
`include "battery_charge_from_voltage_core_macros.svh"

module battery_charge_from_voltage_core #(
    parameter int CURVE_LEN = bcv_pkg::CURVE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bcv_pkg::CODE_W-1:0]   adc_code,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bcv_pkg::MV_W-1:0]     pack_mv,
    output logic [bcv_pkg::PCT_W-1:0]    charge_percent,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcv_pkg::PADDR_W-1:0]  paddr,
    input  logic [bcv_pkg::PDATA_W-1:0]  pwdata,
    output logic [bcv_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int SEG_N = CURVE_LEN - 1;

    // configuration register
    logic [bcv_pkg::MV_W-1:0] fs_reg;
    logic                     cfg_wr;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic load1, load2, load3, load4;

    // stage payload
    logic [bcv_pkg::PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic [bcv_pkg::MV_W-1:0]   s2_mv_reg, s2_mv_next;
    logic [bcv_pkg::MV_W-1:0]   s3_mv_reg;
    logic [bcv_pkg::D_W-1:0]    s3_d_reg, s3_d_next;
    logic [bcv_pkg::MUL_W-1:0]  s3_mul_reg, s3_mul_next;
    logic [bcv_pkg::PCT_W-1:0]  s3_base_reg, s3_base_next;
    logic [bcv_pkg::MV_W-1:0]   s4_mv_reg;
    logic [bcv_pkg::PCT_W-1:0]  s4_pct_reg, s4_pct_next;

    // divide and interpolation intermediates
    logic [bcv_pkg::PROD_W+bcv_pkg::RECIP_W-1:0] div_prod;
    logic [bcv_pkg::D_W+bcv_pkg::MUL_W-1:0]      slope_prod;
    logic [bcv_pkg::D_W-1:0]                     slope_frac;

    // per-segment terms
    logic [SEG_N-1:0]          seg_hit;
    logic [bcv_pkg::D_W-1:0]   seg_d    [SEG_N];
    logic [bcv_pkg::MUL_W-1:0] seg_mul  [SEG_N];
    logic [bcv_pkg::PCT_W-1:0] seg_base [SEG_N];
    logic                      at_top, at_bottom;

    // output-side terms for the checks
    logic                      out_at_top, out_pct_full;

    // ---------------------------------------------------------------
    // apb register
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == bcv_pkg::REG_FULL_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= bcv_pkg::FULL_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            fs_reg <= pwdata[bcv_pkg::MV_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == bcv_pkg::REG_FULL_SCALE)
        begin
            prdata = {{(bcv_pkg::PDATA_W-bcv_pkg::MV_W){1'b0}}, fs_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    assign load4    = !v4_reg || !out_stall;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_stall = !load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= in_valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: code times full scale
    // ---------------------------------------------------------------
    assign s1_prod_next = bcv_pkg::PROD_W'(adc_code) * bcv_pkg::PROD_W'(fs_reg);

    // ---------------------------------------------------------------
    // stage 2: divide by 4095 through the reciprocal
    // ---------------------------------------------------------------
    assign div_prod   = (bcv_pkg::PROD_W+bcv_pkg::RECIP_W)'(s1_prod_reg)
                      * (bcv_pkg::PROD_W+bcv_pkg::RECIP_W)'(bcv_pkg::DIV_RECIP);
    assign s2_mv_next = div_prod[bcv_pkg::DIV_SHIFT +: bcv_pkg::MV_W];

    // ---------------------------------------------------------------
    // stage 3: segment search, offset and slope select
    // ---------------------------------------------------------------
    assign at_top    = (s2_mv_reg >= bcv_pkg::CURVE_MV[0]);
    assign at_bottom = (s2_mv_reg <= bcv_pkg::CURVE_MV[CURVE_LEN-1]);

    for (genvar g = 0; g < SEG_N; g++)
    begin : g_seg
        localparam longint unsigned HI_MV  = longint'(bcv_pkg::CURVE_MV[g]);
        localparam longint unsigned LO_MV  = longint'(bcv_pkg::CURVE_MV[g+1]);
        localparam longint unsigned HI_PCT = longint'(bcv_pkg::CURVE_SOC[g]);
        localparam longint unsigned LO_PCT = longint'(bcv_pkg::CURVE_SOC[g+1]);
        localparam longint unsigned SPAN   = (HI_MV > LO_MV) ? (HI_MV - LO_MV) : 0;
        localparam longint unsigned SDIFF  = (HI_PCT >= LO_PCT) ? (HI_PCT - LO_PCT) : 0;
        localparam longint unsigned SPAN_DIV = (SPAN == 0) ? 1 : SPAN;
        // ceiling of sdiff / span in fixed point; flat segment keeps lower charge
        localparam longint unsigned MUL_FULL = (SPAN == 0) ? 0 :
            ((SDIFF << bcv_pkg::MUL_SHIFT) + SPAN_DIV - 1) / SPAN_DIV;
        localparam logic [bcv_pkg::MUL_W-1:0] MUL = MUL_FULL[bcv_pkg::MUL_W-1:0];

        logic [bcv_pkg::MV_W-1:0] seg_off;

        assign seg_hit[g]  = (s2_mv_reg < bcv_pkg::CURVE_MV[g])
                          && (s2_mv_reg >= bcv_pkg::CURVE_MV[g+1]);
        assign seg_off     = s2_mv_reg - bcv_pkg::CURVE_MV[g+1];
        assign seg_d[g]    = seg_off[bcv_pkg::D_W-1:0];
        assign seg_mul[g]  = MUL;
        assign seg_base[g] = bcv_pkg::CURVE_SOC[g+1];
    end

    // first matching segment wins
    always_comb
    begin
        logic found;
        found        = 1'b0;
        s3_d_next    = '0;
        s3_mul_next  = '0;
        s3_base_next = bcv_pkg::PCT_NONE;
        if (at_top)
        begin
            s3_base_next = bcv_pkg::PCT_FULL;
        end
        else if (!at_bottom)
        begin
            for (int i = 0; i < SEG_N; i++)
            begin
                if (seg_hit[i] && !found)
                begin
                    s3_d_next    = seg_d[i];
                    s3_mul_next  = seg_mul[i];
                    s3_base_next = seg_base[i];
                end
                found = found | seg_hit[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 4: slope times offset plus lower charge
    // ---------------------------------------------------------------
    assign slope_prod  = (bcv_pkg::D_W+bcv_pkg::MUL_W)'(s3_d_reg)
                       * (bcv_pkg::D_W+bcv_pkg::MUL_W)'(s3_mul_reg);
    assign slope_frac  = slope_prod[bcv_pkg::MUL_SHIFT +: bcv_pkg::D_W];
    assign s4_pct_next = s3_base_reg + slope_frac[bcv_pkg::PCT_W-1:0];

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_prod_reg <= s1_prod_next;
        end
        if (load2)
        begin
            s2_mv_reg <= s2_mv_next;
        end
        if (load3)
        begin
            s3_mv_reg   <= s2_mv_reg;
            s3_d_reg    <= s3_d_next;
            s3_mul_reg  <= s3_mul_next;
            s3_base_reg <= s3_base_next;
        end
        if (load4)
        begin
            s4_mv_reg  <= s3_mv_reg;
            s4_pct_reg <= s4_pct_next;
        end
    end

    assign out_valid      = v4_reg;
    assign pack_mv        = s4_mv_reg;
    assign charge_percent = s4_pct_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    assign out_at_top   = (pack_mv >= bcv_pkg::CURVE_MV[0]);
    assign out_pct_full = (charge_percent == bcv_pkg::PCT_FULL);

    `BCV_ASSERT_IMPL(a_pct_range, clk, rst_n, out_valid, charge_percent <= bcv_pkg::PCT_FULL)
    `BCV_ASSERT_IMPL(a_full_at_top, clk, rst_n, out_valid, out_at_top == out_pct_full)
    `BCV_ASSERT_IMPL(a_mv_bound, clk, rst_n, out_valid, pack_mv <= fs_reg)
    `BCV_ASSERT_NEXT(a_take, clk, rst_n, in_valid && !in_stall, v1_reg)

endmodule
